@@ src/annexb_pkg.sv @@
// Shared types and constants for the Annex B NAL unit splitter.
// No dependencies; used by the interfaces and every module of the block.
`default_nettype none

package annexb_pkg;

  localparam int unsigned BYTE_BITS  = 8;
  localparam int unsigned TYPE_BITS  = 5;
  localparam int unsigned TS_BITS    = 32;
  localparam int unsigned FIELD_BITS = 32;
  localparam int unsigned DATA_BITS  = 32;
  localparam int unsigned ADDR_BITS  = 3;

  localparam logic [BYTE_BITS-1:0] ZERO_BYTE       = 8'h00;
  localparam logic [BYTE_BITS-1:0] START_CODE_BYTE = 8'h01;
  localparam logic [TYPE_BITS-1:0] NAL_TYPE_MASK   = 5'h1f;
  localparam logic [TYPE_BITS-1:0] IDR_TYPE        = 5'd5;
  localparam logic [TS_BITS-1:0]   DEFAULT_STEP    = 32'd6750;
  localparam logic [23:0]          HISTORY_RESET   = 24'hff_ffff;

  // register indexes, taken from paddr[2]
  localparam logic REG_TS_BASE = 1'b0;
  localparam logic REG_TS_STEP = 1'b1;

  typedef struct packed {
    logic               base_wr;
    logic [TS_BITS-1:0] wr_value;
    logic [TS_BITS-1:0] base;
    logic [TS_BITS-1:0] step;
  } cfg_t;

endpackage

`default_nettype wire

@@ src/annexb_if.sv @@
// Channel interfaces for the splitter: raw byte stream in, unit records out.
// Depends on annexb_pkg.
`default_nettype none

interface annexb_byte_if;
  logic                               valid;
  logic                               ready;
  logic [annexb_pkg::BYTE_BITS-1:0]   data_byte;
  logic                               last_byte;

  modport source (output valid, data_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface annexb_unit_if;
  logic                               valid;
  logic                               ready;
  logic [annexb_pkg::FIELD_BITS-1:0]  unit_offset;
  logic [annexb_pkg::FIELD_BITS-1:0]  unit_length;
  logic [annexb_pkg::TYPE_BITS-1:0]   unit_type;
  logic                               key_unit;
  logic [annexb_pkg::TS_BITS-1:0]     unit_timestamp;

  modport source (output valid, unit_offset, unit_length, unit_type, key_unit,
                  unit_timestamp, input ready);
  modport sink   (input valid, unit_offset, unit_length, unit_type, key_unit,
                  unit_timestamp, output ready);
endinterface

`default_nettype wire

@@ src/annexb_regs.sv @@
// APB register file: timestamp base and step.
// Depends on annexb_pkg.
`default_nettype none

module annexb_regs (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [annexb_pkg::ADDR_BITS-1:0]  paddr,
  input  wire logic [annexb_pkg::DATA_BITS-1:0]  pwdata,
  output logic      [annexb_pkg::DATA_BITS-1:0]  prdata,
  output logic                                   pready,
  output annexb_pkg::cfg_t                       cfg
);

  logic                              wr;
  logic [annexb_pkg::TS_BITS-1:0]    ts_base;
  logic [annexb_pkg::TS_BITS-1:0]    ts_step;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      ts_base <= '0;
      ts_step <= annexb_pkg::DEFAULT_STEP;
    end else if (wr) begin
      case (paddr[2])
        annexb_pkg::REG_TS_BASE: ts_base <= pwdata;
        annexb_pkg::REG_TS_STEP: ts_step <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      annexb_pkg::REG_TS_BASE: prdata = ts_base;
      annexb_pkg::REG_TS_STEP: prdata = ts_step;
      default:                 prdata = '0;
    endcase
  end

  assign cfg.base_wr  = wr && (paddr[2] == annexb_pkg::REG_TS_BASE);
  assign cfg.wr_value = pwdata;
  assign cfg.base     = ts_base;
  assign cfg.step     = ts_step;

endmodule

`default_nettype wire

@@ src/annexb_parse.sv @@
// Start code scanner: input register, stream state, result register.
// Depends on annexb_pkg and the channel interfaces in annexb_if.sv.
`default_nettype none

module annexb_parse #(
  parameter int unsigned POSITION_BITS = 32
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire annexb_pkg::cfg_t  cfg,
  annexb_byte_if.sink            stream,
  annexb_unit_if.source          units
);

  localparam logic [POSITION_BITS-1:0] POS_ONE   = POSITION_BITS'(1);
  localparam logic [POSITION_BITS-1:0] POS_TWO   = POSITION_BITS'(2);
  localparam logic [POSITION_BITS-1:0] POS_THREE = POSITION_BITS'(3);

  // input register
  logic                               s0_valid;
  logic [annexb_pkg::BYTE_BITS-1:0]   s0_byte;
  logic                               s0_last;

  // stream state
  logic [POSITION_BITS-1:0]           byte_position;
  logic [23:0]                        recent_bytes;
  logic                               unit_open;
  logic                               awaiting_type_byte;
  logic [POSITION_BITS-1:0]           open_unit_start;
  logic [annexb_pkg::TYPE_BITS-1:0]   open_unit_type;
  logic [annexb_pkg::TS_BITS-1:0]     next_timestamp;

  // result register
  logic                               out_valid;
  logic [annexb_pkg::FIELD_BITS-1:0]  out_offset;
  logic [annexb_pkg::FIELD_BITS-1:0]  out_length;
  logic [annexb_pkg::TYPE_BITS-1:0]   out_type;
  logic                               out_key;
  logic [annexb_pkg::TS_BITS-1:0]     out_ts;

  logic                               advance;
  logic                               step_en;
  logic                               is_code;
  logic                               four;
  logic                               emit;
  logic [annexb_pkg::TYPE_BITS-1:0]   eff_type;
  logic [POSITION_BITS-1:0]           end_pos;
  logic [POSITION_BITS-1:0]           unit_len;
  logic [annexb_pkg::TYPE_BITS-1:0]   unit_type_c;
  logic [POSITION_BITS+31:0]          offset_ext;
  logic [POSITION_BITS+31:0]          length_ext;

  assign advance      = !out_valid || units.ready;
  assign stream.ready = !s0_valid || advance;
  assign step_en      = s0_valid && advance;

  always_comb begin
    is_code  = (s0_byte == annexb_pkg::START_CODE_BYTE) &&
               (recent_bytes[15:8] == annexb_pkg::ZERO_BYTE) &&
               (recent_bytes[7:0] == annexb_pkg::ZERO_BYTE);
    four     = recent_bytes[23:16] == annexb_pkg::ZERO_BYTE;
    eff_type = awaiting_type_byte ? (s0_byte[annexb_pkg::TYPE_BITS-1:0] &
                                     annexb_pkg::NAL_TYPE_MASK)
                                  : open_unit_type;
    end_pos  = is_code ? (byte_position - (four ? POS_THREE : POS_TWO))
                       : (byte_position + POS_ONE);
    emit     = unit_open && (is_code || s0_last);
    unit_len = end_pos - open_unit_start;
    unit_type_c = (unit_len == '0) ? '0 : eff_type;
    offset_ext  = {32'd0, open_unit_start};
    length_ext  = {32'd0, unit_len};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (stream.ready) begin
      s0_valid <= stream.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stream.ready) begin
      s0_byte <= stream.data_byte;
      s0_last <= stream.last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position      <= '0;
      recent_bytes       <= annexb_pkg::HISTORY_RESET;
      unit_open          <= 1'b0;
      awaiting_type_byte <= 1'b0;
      open_unit_start    <= '0;
      open_unit_type     <= '0;
      next_timestamp     <= '0;
    end else if (step_en) begin
      if (s0_last) begin
        byte_position      <= '0;
        recent_bytes       <= annexb_pkg::HISTORY_RESET;
        unit_open          <= 1'b0;
        awaiting_type_byte <= 1'b0;
        open_unit_start    <= '0;
        open_unit_type     <= '0;
        next_timestamp     <= cfg.base;
      end else begin
        byte_position <= byte_position + POS_ONE;
        recent_bytes  <= {recent_bytes[15:0], s0_byte};
        if (is_code) begin
          unit_open          <= 1'b1;
          awaiting_type_byte <= 1'b1;
          open_unit_start    <= byte_position + POS_ONE;
          open_unit_type     <= '0;
        end else if (awaiting_type_byte) begin
          awaiting_type_byte <= 1'b0;
          open_unit_type     <= eff_type;
        end
        if (emit) begin
          next_timestamp <= next_timestamp + cfg.step;
        end
      end
    end else if (cfg.base_wr && !unit_open) begin
      next_timestamp <= cfg.wr_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= step_en && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en && emit) begin
      out_offset <= offset_ext[31:0];
      out_length <= length_ext[31:0];
      out_type   <= unit_type_c;
      out_key    <= unit_type_c == annexb_pkg::IDR_TYPE;
      out_ts     <= next_timestamp;
    end
  end

  assign units.valid          = out_valid;
  assign units.unit_offset    = out_offset;
  assign units.unit_length    = out_length;
  assign units.unit_type      = out_type;
  assign units.key_unit       = out_key;
  assign units.unit_timestamp = out_ts;

endmodule

`default_nettype wire

@@ src/annexb_nal_unit_splitter.sv @@
// Annex B NAL unit splitter, top level.
// Depends on annexb_pkg, annexb_if.sv, annexb_regs and annexb_parse.
//
// Takes one stream byte per clock and reports one record per finished NAL
// unit: payload offset, length, type, key flag and timestamp. A byte is held
// in an input register, then the start code logic updates the stream state
// and loads the result register, which presents the record of the unit that
// the byte ends. The sustained rate is one byte per cycle, limited only by
// the single result register, which keeps taking bytes whenever it is empty
// or being drained. Positions are POSITION_BITS wide and reported in their
// low 32 bits. Write the timestamp registers only while the block is idle.
`default_nettype none

module annexb_nal_unit_splitter #(
  parameter int unsigned POSITION_BITS = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  annexb_byte_if.sink                            stream,
  annexb_unit_if.source                          units,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [annexb_pkg::ADDR_BITS-1:0]  paddr,
  input  wire logic [annexb_pkg::DATA_BITS-1:0]  pwdata,
  output logic      [annexb_pkg::DATA_BITS-1:0]  prdata,
  output logic                                   pready
);

  annexb_pkg::cfg_t cfg;

  annexb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  annexb_parse #(
    .POSITION_BITS (POSITION_BITS)
  ) u_parse (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .stream (stream),
    .units  (units)
  );

endmodule

`default_nettype wire

@@ dv/annexb_nal_unit_splitter_tb.sv @@
// Self-checking testbench for annexb_nal_unit_splitter: a short list of start code
// cases, then random Annex B streams checked against a unit predictor kept here.
// Depends on annexb_pkg and the channel interfaces in annexb_if.sv.
`timescale 1ns / 1ps

module annexb_nal_unit_splitter_tb;

  localparam int unsigned POS_W       = 32;
  localparam int          TOTAL_BYTES = 1750;
  localparam int          QUIET_LIMIT = 1000;

  typedef enum int {PACE_NONE, PACE_FULL, PACE_SPARSE} pace_t;
  typedef enum int {END_LAST, END_ON_CODE, END_OPEN, END_NOISE} phase_end_t;

  typedef struct packed {
    logic [annexb_pkg::FIELD_BITS-1:0] offset;
    logic [annexb_pkg::FIELD_BITS-1:0] length;
    logic [annexb_pkg::TYPE_BITS-1:0]  nal_type;
    logic                              key;
    logic [annexb_pkg::TS_BITS-1:0]    stamp;
  } unit_rec_t;

  typedef struct packed {
    logic [annexb_pkg::BYTE_BITS-1:0] data;
    logic                             last;
  } stream_byte_t;

  typedef struct packed {
    logic [annexb_pkg::BYTE_BITS-1:0] data;
    logic                             last;
    logic                             typed;
    unit_rec_t                        want;
  } directed_row_t;

  localparam unit_rec_t NO_UNIT = '0;

  // reset config: base 0, step 6750
  directed_row_t directed_rows [27] = '{
    '{8'hab, 1'b0, 1'b0, NO_UNIT},
    '{8'h00, 1'b0, 1'b0, NO_UNIT},
    '{8'h00, 1'b0, 1'b0, NO_UNIT},
    '{8'h01, 1'b0, 1'b0, NO_UNIT},
    '{8'h65, 1'b0, 1'b0, NO_UNIT},
    '{8'h00, 1'b0, 1'b0, NO_UNIT},
    '{8'h00, 1'b0, 1'b0, NO_UNIT},
    '{8'h00, 1'b0, 1'b0, NO_UNIT},
    '{8'h01, 1'b0, 1'b1, '{32'd4, 32'd1, annexb_pkg::IDR_TYPE, 1'b1, 32'd0}},
    '{8'h00, 1'b0, 1'b0, NO_UNIT},
    '{8'h00, 1'b0, 1'b0, NO_UNIT},
    '{8'h01, 1'b0, 1'b1, '{32'd9, 32'd0, 5'd0, 1'b0, 32'd6750}},
    '{8'h1f, 1'b0, 1'b0, NO_UNIT},
    '{8'h00, 1'b0, 1'b0, NO_UNIT},
    '{8'h00, 1'b0, 1'b0, NO_UNIT},
    '{8'h00, 1'b0, 1'b0, NO_UNIT},
    '{8'h00, 1'b0, 1'b0, NO_UNIT},
    '{8'h01, 1'b0, 1'b1, '{32'd12, 32'd2, annexb_pkg::NAL_TYPE_MASK, 1'b0, 32'd13500}},
    '{8'hff, 1'b1, 1'b1, '{32'd18, 32'd1, annexb_pkg::NAL_TYPE_MASK, 1'b0, 32'd20250}},
    '{8'h01, 1'b1, 1'b0, NO_UNIT},
    '{8'h00, 1'b0, 1'b0, NO_UNIT},
    '{8'h00, 1'b0, 1'b0, NO_UNIT},
    '{8'h01, 1'b0, 1'b0, NO_UNIT},
    '{8'he5, 1'b0, 1'b0, NO_UNIT},
    '{8'h00, 1'b0, 1'b0, NO_UNIT},
    '{8'h00, 1'b0, 1'b0, NO_UNIT},
    '{8'h01, 1'b1, 1'b1, '{32'd3, 32'd1, annexb_pkg::IDR_TYPE, 1'b1, 32'd0}}
  };

  logic                             clk;
  logic                             rst = 1'b1;
  logic                             psel;
  logic                             penable;
  logic                             pwrite;
  logic [annexb_pkg::ADDR_BITS-1:0] paddr;
  logic [annexb_pkg::DATA_BITS-1:0] pwdata;
  logic [annexb_pkg::DATA_BITS-1:0] prdata;
  logic                             pready;

  annexb_byte_if stream_ch ();
  annexb_unit_if unit_ch ();

  annexb_nal_unit_splitter #(.POSITION_BITS(POS_W)) dut (
    .clk     (clk),
    .rst     (rst),
    .stream  (stream_ch),
    .units   (unit_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // unit predictor state
  logic [POS_W-1:0]                 split_pos;
  logic [23:0]                      split_hist;
  logic                             unit_is_open;
  logic                             type_pending;
  logic [POS_W-1:0]                 open_start;
  logic [annexb_pkg::TYPE_BITS-1:0] open_type;
  logic [annexb_pkg::TS_BITS-1:0]   next_stamp;
  logic [annexb_pkg::TS_BITS-1:0]   stamp_base = '0;
  logic [annexb_pkg::TS_BITS-1:0]   stamp_step = annexb_pkg::DEFAULT_STEP;

  unit_rec_t    units_due [$];
  stream_byte_t phase_bytes [$];
  pace_t        src_pace = PACE_NONE;
  pace_t        sink_pace = PACE_NONE;
  int           mismatches = 0;
  int           bytes_fed = 0;
  int           units_checked = 0;
  int           stamp_writes = 0;
  int           quiet_cycles = 0;

  function automatic void begin_stream();
    split_pos    = '0;
    split_hist   = annexb_pkg::HISTORY_RESET;
    unit_is_open = 1'b0;
    type_pending = 1'b0;
    open_start   = '0;
    open_type    = '0;
    next_stamp   = stamp_base;
  endfunction

  function automatic unit_rec_t close_unit(input logic [POS_W-1:0] end_pos);
    logic [POS_W-1:0] len;
    unit_rec_t rec;
    len          = end_pos - open_start;
    rec.offset   = annexb_pkg::FIELD_BITS'(open_start);
    rec.length   = annexb_pkg::FIELD_BITS'(len);
    rec.nal_type = (len == '0) ? '0 : open_type;
    rec.key      = (rec.nal_type == annexb_pkg::IDR_TYPE);
    rec.stamp    = next_stamp;
    next_stamp   = next_stamp + stamp_step;
    return rec;
  endfunction

  function automatic void split_byte(input logic [annexb_pkg::BYTE_BITS-1:0] data,
                                     input logic last,
                                     output logic found, output unit_rec_t rec);
    logic             code;
    logic             four;
    logic [POS_W-1:0] code_start;
    found = 1'b0;
    rec   = NO_UNIT;
    code  = (data == annexb_pkg::START_CODE_BYTE) &&
            (split_hist[15:0] == {annexb_pkg::ZERO_BYTE, annexb_pkg::ZERO_BYTE});
    four  = (split_hist[23:16] == annexb_pkg::ZERO_BYTE);
    if (type_pending) begin
      open_type    = data[annexb_pkg::TYPE_BITS-1:0] & annexb_pkg::NAL_TYPE_MASK;
      type_pending = 1'b0;
    end
    if (code) begin
      code_start = four ? split_pos - POS_W'(3) : split_pos - POS_W'(2);
      if (unit_is_open) begin
        rec   = close_unit(code_start);
        found = 1'b1;
      end
      unit_is_open = 1'b1;
      type_pending = 1'b1;
      open_start   = split_pos + POS_W'(1);
      open_type    = '0;
    end else if (last && unit_is_open) begin
      rec   = close_unit(split_pos + POS_W'(1));
      found = 1'b1;
    end
    split_hist = {split_hist[15:0], data};
    split_pos  = split_pos + POS_W'(1);
    if (last)
      begin_stream();
  endfunction

  function automatic int pace_wait(input pace_t pace);
    case (pace)
      PACE_NONE: return 0;
      PACE_FULL: return $urandom_range(0, 17);
      default:   return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17) : 0;
    endcase
  endfunction

  function automatic logic [annexb_pkg::BYTE_BITS-1:0] any_byte();
    case ($urandom_range(0, 9))
      0, 1:    return annexb_pkg::ZERO_BYTE;
      2:       return annexb_pkg::START_CODE_BYTE;
      default: return 8'($urandom());
    endcase
  endfunction

  function automatic void add_byte(input logic [annexb_pkg::BYTE_BITS-1:0] data,
                                   input logic last);
    phase_bytes.insert(phase_bytes.size(), {data, last});
  endfunction

  function automatic void add_start_code();
    int zeros;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: zeros = 2;
      5, 6, 7:       zeros = 3;
      default:       zeros = $urandom_range(4, 6);
    endcase
    repeat (zeros) add_byte(annexb_pkg::ZERO_BYTE, 1'b0);
    add_byte(annexb_pkg::START_CODE_BYTE, 1'b0);
  endfunction

  function automatic void build_phase(input phase_end_t shape);
    int                               n_units;
    int                               n_payload;
    logic [annexb_pkg::BYTE_BITS-1:0] head;
    phase_bytes.delete();
    if (shape == END_NOISE) begin
      n_payload = $urandom_range(1, 30);
      repeat (n_payload) add_byte(any_byte(), 1'b0);
    end else begin
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 6)) add_byte(any_byte(), 1'b0);
      n_units = $urandom_range(1, 8);
      repeat (n_units) begin
        add_start_code();
        // roughly one in ten units left empty
        if ($urandom_range(0, 9) != 0) begin
          head = 8'($urandom());
          if ($urandom_range(0, 3) == 0)
            head[annexb_pkg::TYPE_BITS-1:0] = annexb_pkg::IDR_TYPE;
          add_byte(head, 1'b0);
          n_payload = ($urandom_range(0, 11) == 0) ? $urandom_range(20, 90)
                                                   : $urandom_range(0, 10);
          repeat (n_payload) add_byte(any_byte(), 1'b0);
        end
      end
      if (shape == END_ON_CODE)
        add_start_code();
    end
    if (shape != END_OPEN)
      phase_bytes[phase_bytes.size() - 1].last = 1'b1;
  endfunction

  task automatic compare_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t ns: %s expected %0d (0x%08h), got %0d (0x%08h)",
               $time, field, want, want, got, got);
    end
  endtask

  // called just after a falling edge, returns just after one
  task automatic feed_byte(input logic [annexb_pkg::BYTE_BITS-1:0] data, input logic last,
                           input logic typed, input unit_rec_t want);
    int        gap;
    logic      found;
    unit_rec_t rec;
    gap = pace_wait(src_pace);
    repeat (gap) @(negedge clk);
    stream_ch.valid     = 1'b1;
    stream_ch.data_byte = data;
    stream_ch.last_byte = last;
    do @(posedge clk); while (!stream_ch.ready);
    split_byte(data, last, found, rec);
    if (typed)
      units_due.insert(units_due.size(), want);
    else if (found)
      units_due.insert(units_due.size(), rec);
    bytes_fed++;
    @(negedge clk);
    stream_ch.valid = 1'b0;
  endtask

  task automatic settle(input int extra);
    while (units_due.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic program_stamp(input logic sel, input logic [annexb_pkg::TS_BITS-1:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {sel, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (sel == annexb_pkg::REG_TS_BASE) begin
      stamp_base = value;
      if (!unit_is_open)
        next_stamp = value;
    end else begin
      stamp_step = value;
    end
    @(negedge clk);
    pwrite  = 1'b0;
    penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    compare_field(sel == annexb_pkg::REG_TS_BASE ? "timestamp_base readback"
                                                 : "timestamp_step readback",
                  value, prdata);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    stamp_writes++;
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((stream_ch.valid && stream_ch.ready) || (unit_ch.valid && unit_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t ns: no transaction for %0d cycles, %0d units outstanding",
               $time, QUIET_LIMIT, units_due.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin : unit_sink
    int        stall;
    unit_rec_t want;
    unit_ch.ready = 1'b0;
    wait (rst == 1'b0);
    @(negedge clk);
    forever begin
      stall = pace_wait(sink_pace);
      if (stall != 0) begin
        unit_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      unit_ch.ready = 1'b1;
      do @(posedge clk); while (!unit_ch.valid);
      if (units_due.size() == 0) begin
        mismatches++;
        $display("%0t ns: unit record expected none, got offset %0d length %0d",
                 $time, unit_ch.unit_offset, unit_ch.unit_length);
      end else begin
        want = units_due.pop_front();
        compare_field("unit_offset", want.offset, unit_ch.unit_offset);
        compare_field("unit_length", want.length, unit_ch.unit_length);
        compare_field("unit_type", 32'(want.nal_type), 32'(unit_ch.unit_type));
        compare_field("key_unit", 32'(want.key), 32'(unit_ch.key_unit));
        compare_field("unit_timestamp", want.stamp, unit_ch.unit_timestamp);
      end
      units_checked++;
      @(negedge clk);
    end
  end

  initial begin : stream_source
    int                             phase;
    int                             hold_at;
    phase_end_t                     shape;
    logic [annexb_pkg::TS_BITS-1:0] step_pick;
    stream_ch.valid     = 1'b0;
    stream_ch.data_byte = '0;
    stream_ch.last_byte = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    begin_stream();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_rows[i])
      feed_byte(directed_rows[i].data, directed_rows[i].last,
                directed_rows[i].typed, directed_rows[i].want);

    phase = 0;
    while (bytes_fed < TOTAL_BYTES) begin
      if (phase < 3 || $urandom_range(0, 2) == 0) begin
        settle(4);
        case (phase)
          0: begin
            program_stamp(annexb_pkg::REG_TS_BASE, '1);
            program_stamp(annexb_pkg::REG_TS_STEP, '1);
          end
          1: begin
            // lands while the previous stream still has a unit open
            program_stamp(annexb_pkg::REG_TS_BASE, '0);
            program_stamp(annexb_pkg::REG_TS_STEP, '0);
          end
          2: begin
            program_stamp(annexb_pkg::REG_TS_BASE, $urandom());
            program_stamp(annexb_pkg::REG_TS_STEP, annexb_pkg::DEFAULT_STEP);
          end
          default: begin
            case ($urandom_range(0, 3))
              0:       step_pick = '0;
              1:       step_pick = '1;
              2:       step_pick = annexb_pkg::DEFAULT_STEP;
              default: step_pick = $urandom();
            endcase
            if ($urandom_range(0, 1) == 0)
              program_stamp(annexb_pkg::REG_TS_BASE, $urandom());
            program_stamp(annexb_pkg::REG_TS_STEP, step_pick);
          end
        endcase
      end

      if (phase % 5 == 1) begin
        src_pace  = PACE_NONE;
        sink_pace = PACE_NONE;
      end else begin
        src_pace  = pace_t'($urandom_range(0, 2));
        sink_pace = pace_t'($urandom_range(0, 2));
      end

      case ($urandom_range(0, 19))
        0, 1, 2: shape = END_ON_CODE;
        3, 4, 5: shape = END_OPEN;
        6, 7, 8: shape = END_NOISE;
        default: shape = END_LAST;
      endcase
      if (phase == 0)
        shape = END_OPEN;

      build_phase(shape);
      hold_at = (phase % 6 == 3) ? $urandom_range(0, phase_bytes.size() - 1) : -1;
      foreach (phase_bytes[i]) begin
        if (i == hold_at)
          settle(0);
        feed_byte(phase_bytes[i].data, phase_bytes[i].last, 1'b0, NO_UNIT);
      end
      phase++;
    end

    settle(8);
    $display("Fed %0d stream bytes in %0d random phases after the start code cases;",
             bytes_fed, phase);
    $display("checked %0d unit records across %0d timestamp register writes.",
             units_checked, stamp_writes);
    if (mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
